// File: rtl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared constants, types and helpers of the subset sum counter.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

    localparam int MAX_SUM    = 1023;
    localparam int DEPTH      = MAX_SUM + 1;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int COUNT_BITS = 32;
    localparam int VALUE_W    = 10;
    localparam int TARGET_W   = 10;
    localparam int OUT_W      = 32;

    localparam logic [63:0] OUT_MAX = 64'h0000_0000_FFFF_FFFF;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RUN,
        ST_FLUSH,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PASS_UPDATE,
        PASS_FILL,
        PASS_CLEAR
    } pass_t;

    typedef struct packed {
        logic              load;
        logic              issue;
        logic [ADDR_W-1:0] addr;
        logic              result_load;
    } ssc_cmd_t;

    typedef struct packed {
        logic out_free;
    } ssc_status_t;

    function automatic logic [OUT_W-1:0] clamp_out(input logic [COUNT_BITS-1:0] c);
        logic [63:0] w;
        begin
            w = 64'(c);
            if (w > OUT_MAX)
            begin
                return '1;
            end
            return w[OUT_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/ssc_ram.sv
// ----------------------------------------------------------------------------
// ssc_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

// File: rtl/ssc_ctrl.sv
// ----------------------------------------------------------------------------
// ssc_ctrl
// Sequencer: sweeps the table from the top sum down to zero once per item.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_ctrl
    import ssc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire ssc_status_t status,
    output ssc_cmd_t         cmd
);

    localparam logic [ADDR_W-1:0] TOP_ADDR = ADDR_W'(MAX_SUM);

    state_t            state_reg;
    state_t            state_next;
    logic [ADDR_W-1:0] j_reg;
    logic [ADDR_W-1:0] j_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            j_reg     <= TOP_ADDR;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        j_next          = j_reg;
        s_tready        = 1'b0;
        cmd.load        = 1'b0;
        cmd.issue       = 1'b0;
        cmd.addr        = j_reg;
        cmd.result_load = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.issue = 1'b1;
                if (j_reg == '0)
                begin
                    j_next     = TOP_ADDR;
                    state_next = ST_IDLE;
                end
                else
                begin
                    j_next = j_reg - ADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                if (j_reg == '0)
                begin
                    j_next     = TOP_ADDR;
                    state_next = ST_FLUSH;
                end
                else
                begin
                    j_next = j_reg - ADDR_W'(1);
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
                j_next     = TOP_ADDR;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/ssc_dp.sv
// ----------------------------------------------------------------------------
// ssc_dp
// Datapath: count table, saturating update, target capture, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_dp
    import ssc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ssc_cmd_t              cmd,
    output ssc_status_t                status,
    input  wire logic [VALUE_W-1:0]    s_value,
    input  wire logic                  s_start,
    input  wire logic                  cfg_we,
    input  wire logic [TARGET_W-1:0]   cfg_wdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_W-1:0]      subset_count,
    output logic                       saturated
);

    logic [VALUE_W-1:0]    value_reg;
    pass_t                 kind_reg;
    pass_t                 kind_next;
    logic [TARGET_W-1:0]   target_reg;
    logic                  s1_vld_reg;
    logic [ADDR_W-1:0]     s1_addr_reg;
    logic [COUNT_BITS-1:0] cap_reg;
    logic                  sat_flag_reg;
    logic                  sat_flag_next;
    logic                  out_vld_reg;
    logic                  out_vld_next;
    logic [OUT_W-1:0]      out_count_reg;
    logic                  out_sat_reg;

    logic [COUNT_BITS-1:0] rd_a;
    logic [COUNT_BITS-1:0] rd_b;
    logic [ADDR_W-1:0]     raddr_b;
    logic [COUNT_BITS:0]   sum;
    logic [COUNT_BITS-1:0] new_count;
    logic                  ovf;
    logic                  v_le_j;
    logic                  hit_value;
    logic                  target_ok;

    assign raddr_b = cmd.addr - ADDR_W'(value_reg);

    ssc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (s1_vld_reg),
        .waddr   (s1_addr_reg),
        .wdata   (new_count),
        .raddr_a (cmd.addr),
        .raddr_b (raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // update of one table entry, in the cycle after its read
    always_comb
    begin
        sum       = {1'b0, rd_a} + {1'b0, rd_b};
        v_le_j    = (32'(value_reg) <= 32'(s1_addr_reg));
        hit_value = (32'(value_reg) == 32'(s1_addr_reg));
        new_count = rd_a;
        ovf       = 1'b0;
        case (kind_reg)
            PASS_UPDATE:
            begin
                if ((s1_addr_reg != '0) && v_le_j)
                begin
                    ovf       = sum[COUNT_BITS];
                    new_count = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
                end
            end
            PASS_FILL:
            begin
                new_count = ((s1_addr_reg == '0) || hit_value) ? COUNT_BITS'(1) : '0;
            end
            default:
            begin
                new_count = (s1_addr_reg == '0) ? COUNT_BITS'(1) : '0;
            end
        endcase
    end

    always_comb
    begin
        kind_next = kind_reg;
        if (cmd.load)
        begin
            kind_next = s_start ? PASS_FILL : PASS_UPDATE;
        end
        sat_flag_next = sat_flag_reg;
        if (cmd.load && s_start)
        begin
            sat_flag_next = 1'b0;
        end
        else if (s1_vld_reg && ovf)
        begin
            sat_flag_next = 1'b1;
        end
        out_vld_next = out_vld_reg;
        if (cmd.result_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= PASS_CLEAR;
            target_reg   <= '0;
            s1_vld_reg   <= 1'b0;
            sat_flag_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            kind_reg     <= kind_next;
            s1_vld_reg   <= cmd.issue;
            sat_flag_reg <= sat_flag_next;
            out_vld_reg  <= out_vld_next;
            if (cfg_we)
            begin
                target_reg <= cfg_wdata;
            end
        end
    end

    assign target_ok = (32'(target_reg) <= MAX_SUM);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= s_value;
        end
        s1_addr_reg <= cmd.addr;
        if (s1_vld_reg && (32'(s1_addr_reg) == 32'(target_reg)))
        begin
            cap_reg <= new_count;
        end
        if (cmd.result_load)
        begin
            out_count_reg <= target_ok ? clamp_out(cap_reg) : '0;
            out_sat_reg   <= sat_flag_reg;
        end
    end

    assign status.out_free = !out_vld_reg || m_tready;
    assign m_tvalid        = out_vld_reg;
    assign subset_count    = out_count_reg;
    assign saturated       = out_sat_reg;

endmodule

`default_nettype wire

// File: rtl/subset_sum_counter_core.sv
// ----------------------------------------------------------------------------
// subset_sum_counter_core
// Counts subsets of a stream of values that sum to a programmable target.
//
//   channel   dir  signals                    contents
//   s_*       in   s_tvalid s_tready s_tdata  value [9:0]; s_tuser[0] start_new
//   m_*       out  m_tvalid m_tready m_tdata  subset_count [31:0]; m_tuser[0] saturated
//   cfg_*     in   cfg_we cfg_wdata           target_sum [9:0]
//
// each item takes one sweep of the count table, one entry a cycle through
// the table write port, plus accept, flush and result steps
// after reset a clearing sweep of the whole table runs with s_tready low
// one result waits in the output register; a stalled result holds the
// sequencer at its last step until the output register is free
// ----------------------------------------------------------------------------
`default_nettype none

module subset_sum_counter_core
    import ssc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // value [9:0], zero [15:10]
    input  wire logic [0:0]  s_tuser,   // start_new [0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // subset_count [31:0]
    output logic      [0:0]  m_tuser,   // saturated [0]
    input  wire logic        cfg_we,
    input  wire logic [9:0]  cfg_wdata  // target_sum [9:0]
);

    ssc_cmd_t    cmd;
    ssc_status_t status;
    logic        sat_bit;

    ssc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ssc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .s_value      (s_tdata[VALUE_W-1:0]),
        .s_start      (s_tuser[0]),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .subset_count (m_tdata),
        .saturated    (sat_bit)
    );

    assign m_tuser[0] = sat_bit;

    a_busy_after_accept : assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready
    ) else $error("input taken again while a sweep is running");

    a_no_result_overwrite : assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> (!m_tvalid || m_tready)
    ) else $error("result loaded over a pending transfer");

    a_no_issue_on_load : assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!cmd.issue && !cmd.result_load)
    ) else $error("table access while an item is taken");

endmodule

`default_nettype wire
